### hdl/pps_pkg.sv
package pps_pkg;

    localparam int ENTRY_COUNT = 4096;
    localparam int MAX_WIDTH   = 8;
    localparam int SLOT_COUNT  = 256;
    localparam int WORD_COUNT  = ENTRY_COUNT * MAX_WIDTH / 32;

    localparam int POS_W   = 12;
    localparam int CODE_W  = 16;
    localparam int CNT_W   = 13;
    localparam int SLOT_W  = 8;
    localparam int LEN_W   = 9;
    localparam int WIDTH_W = 4;
    localparam int WADDR_W = 10;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_FILL = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_OPT  = 2'd3;

    localparam logic [1:0] ST_CHANGED   = 2'd0;
    localparam logic [1:0] ST_UNCHANGED = 2'd1;
    localparam logic [1:0] ST_REJECTED  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic CFG_AIR   = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic [31:0]        word;
        logic [WIDTH_W-1:0] width;
        logic [POS_W-1:0]   position;
        logic [SLOT_W-1:0]  value;
    } t_field_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  field;
        logic [31:0]        word;
        logic [WADDR_W-1:0] addr;
        logic               last;
    } t_field_rsp;

    function automatic logic [WIDTH_W-1:0] fitting_width(input logic [LEN_W-1:0] n);
        logic [WIDTH_W-1:0] w;
        if (n <= LEN_W'(2)) begin
            w = WIDTH_W'(1);
        end else if (n <= LEN_W'(4)) begin
            w = WIDTH_W'(2);
        end else if (n <= LEN_W'(16)) begin
            w = WIDTH_W'(4);
        end else begin
            w = WIDTH_W'(MAX_WIDTH);
        end
        return w;
    endfunction

endpackage

### hdl/pps_ram.sv
module pps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/pps_field.sv
module pps_field
    import pps_pkg::*;
(
    input  t_field_req i_req,
    output t_field_rsp o_rsp
);

    logic [1:0]  sh;
    logic [14:0] bitpos;
    logic [4:0]  off;
    logic [31:0] mask;

    always_comb begin
        if (i_req.width[3]) begin
            sh = 2'd3;
        end else if (i_req.width[2]) begin
            sh = 2'd2;
        end else if (i_req.width[1]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
    end

    assign bitpos = {3'b000, i_req.position} << sh;
    assign off    = bitpos[4:0];
    assign mask   = (32'd1 << i_req.width) - 32'd1;

    assign o_rsp.addr  = bitpos[14:5];
    assign o_rsp.field = SLOT_W'((i_req.word >> off) & mask);
    assign o_rsp.word  = (i_req.word & ~(mask << off))
                       | ((32'(i_req.value) & mask) << off);
    assign o_rsp.last  = ({1'b0, off} + {2'b00, i_req.width}) == 6'd32;

endmodule

### hdl/palette_packed_block_store.sv
// Palette compressed store of 4096 16-bit block codes, indexes packed at
// 0/1/2/4/8 bits in 32-bit words. One transaction in, one result out. A
// sequencer drives a single shared field extract/insert shifter and
// single-port-read RAMs. A set that is not rejected, not equal to the
// uniform code and not already at the position scans the palette slot by
// slot for its code or a free slot, else appends one. A set that widens
// the indexes (leaving uniform mode included) and an optimize that
// compacts the palette or narrows the indexes add a repack of all 4096
// positions, each read, extracted and written from one packed word RAM
// bank into the other. The input is ready only when the sequencer is
// idle; a finished result is held in an output register while the next
// transaction is taken.
module palette_packed_block_store
    import pps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // position [11:0], block_code [27:12]
    input  logic [31:0] i_s_axis_tdata,
    // operation [1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // read_code [15:0], non_air_count [28:16], index_width [32:29],
    // palette_entries [41:33]
    output logic [47:0] o_m_axis_tdata,
    // status [1:0]
    output logic [1:0]  o_m_axis_tuser
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DONE    = 5'd1;
    localparam logic [4:0] S_SET_RD  = 5'd2;
    localparam logic [4:0] S_SET_EX  = 5'd3;
    localparam logic [4:0] S_SET_CMP = 5'd4;
    localparam logic [4:0] S_SC_RD   = 5'd5;
    localparam logic [4:0] S_SC_CK   = 5'd6;
    localparam logic [4:0] S_APPEND  = 5'd7;
    localparam logic [4:0] S_CU_RD   = 5'd8;
    localparam logic [4:0] S_CU_WO   = 5'd9;
    localparam logic [4:0] S_CU_WN   = 5'd10;
    localparam logic [4:0] S_PUT_RD  = 5'd11;
    localparam logic [4:0] S_PUT_WR  = 5'd12;
    localparam logic [4:0] S_RD_RD   = 5'd13;
    localparam logic [4:0] S_RD_EX   = 5'd14;
    localparam logic [4:0] S_RD_CODE = 5'd15;
    localparam logic [4:0] S_OP_RD   = 5'd16;
    localparam logic [4:0] S_OP_CK   = 5'd17;
    localparam logic [4:0] S_OP_END  = 5'd18;
    localparam logic [4:0] S_RP_RD   = 5'd19;
    localparam logic [4:0] S_RP_EX   = 5'd20;
    localparam logic [4:0] S_RP_WR   = 5'd21;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(ENTRY_COUNT - 1);

    logic [4:0]         r_state;
    logic [CODE_W-1:0]  r_air;
    logic [CODE_W-1:0]  r_limit;
    logic [LEN_W-1:0]   r_len;
    logic [WIDTH_W-1:0] r_width;
    logic [CODE_W-1:0]  r_uni;
    logic [CNT_W-1:0]   r_occ;
    logic               r_bank;
    logic [POS_W-1:0]   r_pos;
    logic [CODE_W-1:0]  r_code;
    logic [1:0]         r_status;
    logic [CODE_W-1:0]  r_rd;
    logic [SLOT_W-1:0]  r_old_slot;
    logic [CODE_W-1:0]  r_old_code;
    logic [SLOT_W-1:0]  r_new_slot;
    logic [LEN_W-1:0]   r_idx;
    logic               r_free_ok;
    logic [SLOT_W-1:0]  r_free;
    logic [LEN_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_total;
    logic [CODE_W-1:0]  r_first;
    logic [POS_W-1:0]   r_p;
    logic [WIDTH_W-1:0] r_src_w;
    logic [WIDTH_W-1:0] r_dst_w;
    logic               r_remap_on;
    logic [31:0]        r_asm;
    logic [SLOT_W-1:0]  r_slot;
    logic [4:0]         r_after;
    logic               r_out_valid;
    logic [47:0]        r_out_tdata;
    logic [1:0]         r_out_tuser;

    logic [POS_W-1:0]  in_pos;
    logic [CODE_W-1:0] in_code;
    logic              accept;
    logic              out_load;

    logic               code_we;
    logic [SLOT_W-1:0]  code_waddr;
    logic [CODE_W-1:0]  code_wdata;
    logic [SLOT_W-1:0]  code_raddr;
    logic [CODE_W-1:0]  code_rdata;
    logic               cnt_we;
    logic [SLOT_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [SLOT_W-1:0]  cnt_raddr;
    logic [CNT_W-1:0]   cnt_rdata;
    logic               map_we;
    logic [SLOT_W-1:0]  map_waddr;
    logic [SLOT_W-1:0]  map_wdata;
    logic [SLOT_W-1:0]  map_raddr;
    logic [SLOT_W-1:0]  map_rdata;
    logic               pk_we0;
    logic               pk_we1;
    logic               pk_we;
    logic               pk_wbank;
    logic [WADDR_W-1:0] pk_waddr;
    logic [31:0]        pk_wdata;
    logic [WADDR_W-1:0] pk_raddr;
    logic [31:0]        pk_rdata0;
    logic [31:0]        pk_rdata1;
    logic [31:0]        pk_rdata;

    t_field_req        fld_req;
    t_field_rsp        fld_rsp;
    logic [SLOT_W-1:0] rp_value;
    logic              scan_end;
    logic [WIDTH_W-1:0] fit_w;

    assign in_pos   = i_s_axis_tdata[11:0];
    assign in_code  = i_s_axis_tdata[27:12];
    assign accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
    assign pk_rdata = r_bank ? pk_rdata1 : pk_rdata0;
    assign rp_value = r_remap_on ? map_rdata : r_slot;
    assign scan_end = r_idx >= r_len;
    assign fit_w    = fitting_width(r_n);

    always_comb begin
        fld_req.word     = pk_rdata;
        fld_req.width    = r_width;
        fld_req.position = r_pos;
        fld_req.value    = r_new_slot;
        case (r_state)
            S_RP_RD, S_RP_EX: begin
                fld_req.width    = r_src_w;
                fld_req.position = r_p;
            end
            S_RP_WR: begin
                fld_req.word     = r_asm;
                fld_req.width    = r_dst_w;
                fld_req.position = r_p;
                fld_req.value    = rp_value;
            end
            default: begin
            end
        endcase
    end

    pps_field u_field (
        .i_req (fld_req),
        .o_rsp (fld_rsp)
    );

    always_comb begin
        code_we    = 1'b0;
        code_waddr = '0;
        code_wdata = r_code;
        code_raddr = r_idx[SLOT_W-1:0];
        cnt_we     = 1'b0;
        cnt_waddr  = '0;
        cnt_wdata  = '0;
        cnt_raddr  = r_idx[SLOT_W-1:0];
        map_we     = 1'b0;
        map_waddr  = r_idx[SLOT_W-1:0];
        map_wdata  = r_n[SLOT_W-1:0];
        map_raddr  = fld_rsp.field;
        pk_we      = 1'b0;
        pk_wbank   = r_bank;
        pk_waddr   = fld_rsp.addr;
        pk_wdata   = fld_rsp.word;
        pk_raddr   = fld_rsp.addr;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_s_axis_tuser == OP_SET) && (r_width == '0)
                        && (in_code <= r_limit) && (in_code != r_uni)) begin
                    code_we    = 1'b1;
                    code_wdata = r_uni;
                    cnt_we     = 1'b1;
                    cnt_wdata  = CNT_W'(ENTRY_COUNT);
                end
            end
            S_SET_EX, S_RD_EX: begin
                code_raddr = fld_rsp.field;
            end
            S_SC_RD: begin
                if (scan_end && r_free_ok) begin
                    code_we    = 1'b1;
                    code_waddr = r_free;
                end
            end
            S_APPEND: begin
                code_we    = 1'b1;
                code_waddr = r_len[SLOT_W-1:0];
                cnt_we     = 1'b1;
                cnt_waddr  = r_len[SLOT_W-1:0];
            end
            S_CU_RD: begin
                cnt_raddr = r_old_slot;
            end
            S_CU_WO: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_old_slot;
                cnt_wdata = cnt_rdata - CNT_W'(1);
                cnt_raddr = r_new_slot;
            end
            S_CU_WN: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_new_slot;
                cnt_wdata = cnt_rdata + CNT_W'(1);
            end
            S_PUT_WR: begin
                pk_we = 1'b1;
            end
            S_OP_CK: begin
                if (cnt_rdata != '0) begin
                    code_we    = 1'b1;
                    code_waddr = r_n[SLOT_W-1:0];
                    code_wdata = code_rdata;
                    cnt_we     = 1'b1;
                    cnt_waddr  = r_n[SLOT_W-1:0];
                    cnt_wdata  = cnt_rdata;
                    map_we     = 1'b1;
                end
            end
            S_RP_WR: begin
                pk_we    = fld_rsp.last;
                pk_wbank = !r_bank;
            end
            default: begin
            end
        endcase
    end

    assign pk_we0 = pk_we && !pk_wbank;
    assign pk_we1 = pk_we && pk_wbank;

    pps_ram #(.WIDTH(32), .DEPTH(WORD_COUNT)) u_pk0 (
        .i_clk (i_clk), .i_we (pk_we0), .i_waddr (pk_waddr), .i_wdata (pk_wdata),
        .i_raddr (pk_raddr), .o_rdata (pk_rdata0)
    );

    pps_ram #(.WIDTH(32), .DEPTH(WORD_COUNT)) u_pk1 (
        .i_clk (i_clk), .i_we (pk_we1), .i_waddr (pk_waddr), .i_wdata (pk_wdata),
        .i_raddr (pk_raddr), .o_rdata (pk_rdata1)
    );

    pps_ram #(.WIDTH(CODE_W), .DEPTH(SLOT_COUNT)) u_codes (
        .i_clk (i_clk), .i_we (code_we), .i_waddr (code_waddr), .i_wdata (code_wdata),
        .i_raddr (code_raddr), .o_rdata (code_rdata)
    );

    pps_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_COUNT)) u_counts (
        .i_clk (i_clk), .i_we (cnt_we), .i_waddr (cnt_waddr), .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr), .o_rdata (cnt_rdata)
    );

    pps_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_remap (
        .i_clk (i_clk), .i_we (map_we), .i_waddr (map_waddr), .i_wdata (map_wdata),
        .i_raddr (map_raddr), .o_rdata (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_air       <= '0;
            r_limit     <= '1;
            r_len       <= '0;
            r_width     <= '0;
            r_uni       <= '0;
            r_occ       <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AIR:   r_air   <= i_cfg_wdata;
                    CFG_LIMIT: r_limit <= i_cfg_wdata;
                    default:   r_air   <= r_air;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_tuser <= r_status;
                r_out_tdata <= {6'd0, r_len, r_width, r_occ, r_rd};
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pos  <= in_pos;
                        r_code <= in_code;
                        r_rd   <= '0;
                        r_idx  <= '0;
                        r_n    <= '0;
                        r_total <= '0;
                        r_free_ok <= 1'b0;
                        r_state <= S_DONE;
                        case (i_s_axis_tuser)
                            OP_SET: begin
                                if (in_code > r_limit) begin
                                    r_status <= ST_REJECTED;
                                end else if (r_width == '0) begin
                                    if (in_code == r_uni) begin
                                        r_status <= ST_UNCHANGED;
                                    end else begin
                                        r_len      <= LEN_W'(1);
                                        r_p        <= '0;
                                        r_src_w    <= '0;
                                        r_dst_w    <= WIDTH_W'(1);
                                        r_remap_on <= 1'b0;
                                        r_after    <= S_SET_RD;
                                        r_state    <= S_RP_RD;
                                    end
                                end else begin
                                    r_state <= S_SET_RD;
                                end
                            end
                            OP_FILL: begin
                                r_uni    <= in_code;
                                r_width  <= '0;
                                r_len    <= '0;
                                r_occ    <= (in_code == r_air) ? '0 : CNT_W'(ENTRY_COUNT);
                                r_status <= ST_CHANGED;
                            end
                            OP_READ: begin
                                r_status <= ST_UNCHANGED;
                                if (r_width == '0) begin
                                    r_rd <= r_uni;
                                end else begin
                                    r_state <= S_RD_RD;
                                end
                            end
                            default: begin
                                if (r_width == '0) begin
                                    r_status <= ST_UNCHANGED;
                                end else begin
                                    r_state <= S_OP_RD;
                                end
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SET_RD: begin
                    r_state <= S_SET_EX;
                end
                S_SET_EX: begin
                    r_old_slot <= fld_rsp.field;
                    r_state    <= S_SET_CMP;
                end
                S_SET_CMP: begin
                    r_old_code <= code_rdata;
                    if (code_rdata == r_code) begin
                        r_status <= ST_UNCHANGED;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_RD: begin
                    if (!scan_end) begin
                        r_state <= S_SC_CK;
                    end else if (r_free_ok) begin
                        r_new_slot <= r_free;
                        r_state    <= S_CU_RD;
                    end else if (r_len >= (LEN_W'(1) << r_width)) begin
                        if (r_width == WIDTH_W'(MAX_WIDTH)) begin
                            r_status <= ST_OVERFLOW;
                            r_state  <= S_DONE;
                        end else begin
                            r_p        <= '0;
                            r_src_w    <= r_width;
                            r_dst_w    <= r_width << 1;
                            r_remap_on <= 1'b0;
                            r_after    <= S_APPEND;
                            r_state    <= S_RP_RD;
                        end
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_SC_CK: begin
                    if (code_rdata == r_code) begin
                        r_new_slot <= r_idx[SLOT_W-1:0];
                        r_state    <= S_CU_RD;
                    end else begin
                        if ((cnt_rdata == '0) && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_idx[SLOT_W-1:0];
                        end
                        r_idx   <= r_idx + LEN_W'(1);
                        r_state <= S_SC_RD;
                    end
                end
                S_APPEND: begin
                    r_new_slot <= r_len[SLOT_W-1:0];
                    r_len      <= r_len + LEN_W'(1);
                    r_state    <= S_CU_RD;
                end
                S_CU_RD: begin
                    r_state <= S_CU_WO;
                end
                S_CU_WO: begin
                    r_state <= S_CU_WN;
                end
                S_CU_WN: begin
                    r_state <= S_PUT_RD;
                end
                S_PUT_RD: begin
                    r_state <= S_PUT_WR;
                end
                S_PUT_WR: begin
                    r_occ <= r_occ + ((r_code != r_air) ? CNT_W'(1) : '0)
                                   - ((r_old_code != r_air) ? CNT_W'(1) : '0);
                    r_status <= ST_CHANGED;
                    r_state  <= S_DONE;
                end
                S_RD_RD: begin
                    r_state <= S_RD_EX;
                end
                S_RD_EX: begin
                    r_state <= S_RD_CODE;
                end
                S_RD_CODE: begin
                    r_rd    <= code_rdata;
                    r_state <= S_DONE;
                end
                S_OP_RD: begin
                    r_state <= scan_end ? S_OP_END : S_OP_CK;
                end
                S_OP_CK: begin
                    if (cnt_rdata != '0) begin
                        r_n <= r_n + LEN_W'(1);
                        if (r_n == '0) begin
                            r_first <= code_rdata;
                        end
                        if (code_rdata != r_air) begin
                            r_total <= r_total + cnt_rdata;
                        end
                    end
                    r_idx   <= r_idx + LEN_W'(1);
                    r_state <= S_OP_RD;
                end
                S_OP_END: begin
                    r_state <= S_DONE;
                    if (r_n <= LEN_W'(1)) begin
                        r_uni    <= r_first;
                        r_width  <= '0;
                        r_len    <= '0;
                        r_occ    <= (r_first == r_air) ? '0 : CNT_W'(ENTRY_COUNT);
                        r_status <= ST_CHANGED;
                    end else begin
                        r_occ <= r_total;
                        if ((r_n != r_len) || (fit_w != r_width)) begin
                            r_len      <= r_n;
                            r_p        <= '0;
                            r_src_w    <= r_width;
                            r_dst_w    <= fit_w;
                            r_remap_on <= 1'b1;
                            r_after    <= S_DONE;
                            r_status   <= ST_CHANGED;
                            r_state    <= S_RP_RD;
                        end else begin
                            r_status <= ST_UNCHANGED;
                        end
                    end
                end
                S_RP_RD: begin
                    r_state <= S_RP_EX;
                end
                S_RP_EX: begin
                    r_slot  <= fld_rsp.field;
                    r_state <= S_RP_WR;
                end
                S_RP_WR: begin
                    r_asm <= fld_rsp.word;
                    if (r_p == LAST_POS) begin
                        r_bank  <= !r_bank;
                        r_width <= r_dst_w;
                        r_state <= r_after;
                    end else begin
                        r_p     <= r_p + POS_W'(1);
                        r_state <= S_RP_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

endmodule
